// ----- hdl/ahfr_pkg.sv -----
// ----------------------------------------------------------------------------
// ahfr_pkg
// Shared constants, types and hex helpers for the ASCII hex frame receiver.
// ----------------------------------------------------------------------------
package ahfr_pkg;

  localparam int unsigned MAX_FRAME_CHARS = 340;
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_CHARS + 2);

  localparam logic [7:0] CHAR_SOF = 8'h7E;
  localparam logic [7:0] CHAR_EOF = 8'h0D;
  localparam logic [7:0] CHAR_TWO = 8'h32;
  localparam logic [7:0] CHAR_ONE = 8'h31;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [2:0] NIB_MASK = 3'h7;

  localparam int unsigned NUM_LISTENERS = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_TIMEOUT = 3'd0,
    REG_LISTENER_CNT = 3'd1,
    REG_LISTENER_A0  = 3'd2,
    REG_LISTENER_A1  = 3'd3,
    REG_LISTENER_A2  = 3'd4,
    REG_LISTENER_A3  = 3'd5
  } ahfr_reg_e;

  typedef enum logic [2:0] {
    ST_GOOD      = 3'd0,
    ST_PREFIX_OK = 3'd1,
    ST_CSUM_ERR  = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_TOO_SHORT = 3'd4
  } ahfr_status_e;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_VERDICT = 1'b1
  } ahfr_kind_e;

  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_TICK = 1'b1
  } ahfr_mode_e;

  typedef struct packed {
    logic [15:0]                    idle_timeout_ms;
    logic [2:0]                     listener_count;
    logic [NUM_LISTENERS-1:0][7:0]  listener_addr;
  } ahfr_cfg_t;

  typedef struct packed {
    ahfr_kind_e   kind;
    logic [7:0]   payload_byte;
    logic [7:0]   byte_index;
    ahfr_status_e status;
    logic [3:0]   match_mask;
    logic [15:0]  computed_sum;
  } ahfr_result_t;

  function automatic logic [7:0] nib(input logic [7:0] c);
    logic [7:0] r;
    if (c <= CHAR_NINE) begin
      r = c - CHAR_ZERO;
    end else begin
      r = {5'd0, c[2:0] & NIB_MASK} + 8'd9;
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_pair(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] na;
    na = nib(a);
    return {na[3:0], 4'd0} + nib(b);
  endfunction

endpackage

// ----- hdl/ahfr_decoder.sv -----
// ----------------------------------------------------------------------------
// ahfr_decoder
// Frame state and per-item update: framing, hex decode, checksum, verdict, idle timeout.
// ----------------------------------------------------------------------------
module ahfr_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 mode_i,
  input  logic [7:0]           rx_byte_i,
  input  ahfr_pkg::ahfr_cfg_t  cfg_i,
  output logic                 res_valid_o,
  output ahfr_pkg::ahfr_result_t res_o
);
  import ahfr_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_CHARS);
  localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(5);

  logic             in_frame_q, in_frame_d;
  logic [CNT_W-1:0] char_count_q, char_count_d;
  logic [3:0][7:0]  tail_q, tail_d;
  logic [15:0]      char_sum_q, char_sum_d;
  logic [3:0]       high_nibble_q, high_nibble_d;
  logic             half_pair_q, half_pair_d;
  logic [7:0]       out_index_q, out_index_d;
  logic [1:0]       prefix_q, prefix_d;
  logic [7:0]       address_q, address_d;
  logic [15:0]      idle_ms_q, idle_ms_d;

  logic [15:0]  idle_inc;
  logic [15:0]  remote;
  logic [15:0]  neg_sum;
  logic [7:0]   nib_c;
  logic [3:0]   mask;

  always_comb begin
    in_frame_d    = in_frame_q;
    char_count_d  = char_count_q;
    tail_d        = tail_q;
    char_sum_d    = char_sum_q;
    high_nibble_d = high_nibble_q;
    half_pair_d   = half_pair_q;
    out_index_d   = out_index_q;
    prefix_d      = prefix_q;
    address_d     = address_q;
    idle_ms_d     = idle_ms_q;
    res_valid_o   = 1'b0;
    res_o         = '0;

    idle_inc = (idle_ms_q == 16'hFFFF) ? idle_ms_q : idle_ms_q + 16'd1;
    remote   = {hex_pair(tail_q[0], tail_q[1]), hex_pair(tail_q[2], tail_q[3])};
    neg_sum  = ~char_sum_q + 16'd1;
    nib_c    = nib(tail_q[0]);
    for (int i = 0; i < NUM_LISTENERS; i++) begin
      mask[i] = (3'(i) < cfg_i.listener_count) && (cfg_i.listener_addr[i] == address_q);
    end

    if (step_i) begin
      if (mode_i == MODE_TICK) begin
        idle_ms_d = idle_inc;
        if (idle_inc > cfg_i.idle_timeout_ms) begin
          in_frame_d    = 1'b0;
          char_count_d  = '0;
          tail_d        = '0;
          char_sum_d    = '0;
          high_nibble_d = '0;
          half_pair_d   = 1'b0;
          out_index_d   = '0;
          prefix_d      = '0;
          address_d     = '0;
          idle_ms_d     = '0;
        end
      end else if (!in_frame_q) begin
        if (rx_byte_i == CHAR_SOF) begin
          in_frame_d   = 1'b1;
          char_count_d = CNT_W'(1);
          idle_ms_d    = '0;
        end
      end else if (rx_byte_i == CHAR_EOF) begin
        res_valid_o     = 1'b1;
        res_o.kind      = KIND_VERDICT;
        res_o.byte_index = out_index_q;
        if (char_count_q > MAX_CNT) begin
          res_o.status = ST_TOO_LONG;
        end else if (char_count_q < MIN_CNT) begin
          res_o.status = ST_TOO_SHORT;
        end else begin
          res_o.computed_sum = neg_sum;
          if (neg_sum != remote && prefix_q != 2'b11) begin
            res_o.status = ST_CSUM_ERR;
          end else if (out_index_q < 8'd2) begin
            res_o.status = ST_TOO_SHORT;
          end else begin
            res_o.status     = (neg_sum == remote) ? ST_GOOD : ST_PREFIX_OK;
            res_o.match_mask = mask;
          end
        end
        in_frame_d    = 1'b0;
        char_count_d  = '0;
        tail_d        = '0;
        char_sum_d    = '0;
        high_nibble_d = '0;
        half_pair_d   = 1'b0;
        out_index_d   = '0;
        prefix_d      = '0;
        address_d     = '0;
      end else begin
        idle_ms_d = '0;
        if (char_count_q == CNT_W'(1) && rx_byte_i == CHAR_TWO) begin
          prefix_d[0] = 1'b1;
        end
        if (char_count_q == CNT_W'(2) && rx_byte_i == CHAR_ONE) begin
          prefix_d[1] = 1'b1;
        end
        if (char_count_q >= MIN_CNT && char_count_q < MAX_CNT) begin
          char_sum_d = char_sum_q + {8'd0, tail_q[0]};
          if (!half_pair_q) begin
            high_nibble_d = nib_c[3:0];
            half_pair_d   = 1'b1;
          end else begin
            half_pair_d        = 1'b0;
            res_valid_o        = 1'b1;
            res_o.kind         = KIND_BYTE;
            res_o.payload_byte = {high_nibble_q, 4'd0} + nib_c;
            res_o.byte_index   = out_index_q;
            res_o.status       = ST_GOOD;
            if (out_index_q == 8'd1) begin
              address_d = {high_nibble_q, 4'd0} + nib_c;
            end
            out_index_d = out_index_q + 8'd1;
          end
        end
        tail_d = {rx_byte_i, tail_q[3], tail_q[2], tail_q[1]};
        if (char_count_q <= MAX_CNT) begin
          char_count_d = char_count_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q    <= 1'b0;
      char_count_q  <= '0;
      tail_q        <= '0;
      char_sum_q    <= '0;
      high_nibble_q <= '0;
      half_pair_q   <= 1'b0;
      out_index_q   <= '0;
      prefix_q      <= '0;
      address_q     <= '0;
      idle_ms_q     <= '0;
    end else begin
      in_frame_q    <= in_frame_d;
      char_count_q  <= char_count_d;
      tail_q        <= tail_d;
      char_sum_q    <= char_sum_d;
      high_nibble_q <= high_nibble_d;
      half_pair_q   <= half_pair_d;
      out_index_q   <= out_index_d;
      prefix_q      <= prefix_d;
      address_q     <= address_d;
      idle_ms_q     <= idle_ms_d;
    end
  end

endmodule

// ----- hdl/ahfr_out_reg.sv -----
// ----------------------------------------------------------------------------
// ahfr_out_reg
// Result register with valid/ready toward the output stream.
// ----------------------------------------------------------------------------
module ahfr_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  ahfr_pkg::ahfr_result_t res_i,
  output logic                   free_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output ahfr_pkg::ahfr_result_t res_o
);
  import ahfr_pkg::*;

  logic         valid_q, valid_d;
  ahfr_result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ----- hdl/ascii_hex_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// ascii_hex_frame_receiver
// Receives 0x7E ... 0x0D framed ASCII-hex serial data with a 4-character hex
// checksum, streams decoded payload bytes and one verdict per frame.
// ----------------------------------------------------------------------------
// Takes one item (a received byte or a millisecond tick) every clock cycle
// unless input tready is low. Each item is handled in the cycle it is
// accepted and its result, if any, appears on the output stream in the next
// cycle from a single result register. Input tready falls only while that
// register holds a result that the output side is not taking. Payload bytes
// trail the input by four characters; the verdict follows the 0x0D byte.
// Configuration writes are always ready and take effect on the next cycle.
// ----------------------------------------------------------------------------
module ascii_hex_frame_receiver (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // rx_byte
  input  logic                              s_axis_tuser,  // mode
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // payload_byte[7:0], byte_index[15:8], status[18:16], match_mask[22:19],
  // computed_sum[38:23], zero[39]
  output logic [ahfr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser,  // kind
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ahfr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ahfr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ahfr_pkg::*;

  ahfr_cfg_t    cfg_q, cfg_d;
  ahfr_result_t dec_res;
  ahfr_result_t out_res;
  logic         dec_valid;
  logic         out_free;
  logic         step;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = out_free;
  assign step          = s_axis_tvalid && out_free;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (ahfr_reg_e'(cfg_index_i))
        REG_IDLE_TIMEOUT: cfg_d.idle_timeout_ms  = cfg_data_i;
        REG_LISTENER_CNT: cfg_d.listener_count   = cfg_data_i[2:0];
        REG_LISTENER_A0:  cfg_d.listener_addr[0] = cfg_data_i[7:0];
        REG_LISTENER_A1:  cfg_d.listener_addr[1] = cfg_data_i[7:0];
        REG_LISTENER_A2:  cfg_d.listener_addr[2] = cfg_data_i[7:0];
        REG_LISTENER_A3:  cfg_d.listener_addr[3] = cfg_data_i[7:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{idle_timeout_ms: 16'd150, listener_count: 3'd0, listener_addr: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ahfr_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .mode_i      (s_axis_tuser),
    .rx_byte_i   (s_axis_tdata),
    .cfg_i       (cfg_q),
    .res_valid_o (dec_valid),
    .res_o       (dec_res)
  );

  ahfr_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (dec_valid),
    .res_i   (dec_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {1'b0, out_res.computed_sum, out_res.match_mask, out_res.status,
                         out_res.byte_index, out_res.payload_byte};

endmodule
